>>> src/mmc3_bank_mapper_irq_unit_macros.svh
// Assertion macros shared by the mapper RTL.
`ifndef MMC3_BANK_MAPPER_IRQ_UNIT_MACROS_SVH
`define MMC3_BANK_MAPPER_IRQ_UNIT_MACROS_SVH
`ifndef SYNTH
`define MMC3_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define MMC3_ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
`else
`define MMC3_ASSERT(label, clk, rstn, prop, msg)
`define MMC3_ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg)
`endif
`endif

>>> src/mmc3_pkg.sv
// Shared types and constants of the mapper.
package mmc3_pkg;

    localparam int RAM_IDX_W   = 13;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef enum logic [2:0] {
        KIND_NONE   = 3'd0,
        KIND_RAM_WR = 3'd1,
        KIND_RAM_RD = 3'd2,
        KIND_REG_WR = 3'd3,
        KIND_PRG_RD = 3'd4,
        KIND_PPU    = 3'd5
    } kind_t;

    localparam logic [1:0] OP_CPU_WRITE = 2'd0;
    localparam logic [1:0] OP_CPU_READ  = 2'd1;
    localparam logic [1:0] OP_PPU       = 2'd2;
    localparam logic [1:0] OP_UNUSED    = 2'd3;

    localparam logic [1:0] REG_BANK   = 2'd0;
    localparam logic [1:0] REG_MIRROR = 2'd1;
    localparam logic [1:0] REG_LATCH  = 2'd2;
    localparam logic [1:0] REG_IRQ_EN = 2'd3;

    // Bank select targets held in command bits 2..0
    localparam logic [2:0] SEL_CHR_2K_0 = 3'd0;
    localparam logic [2:0] SEL_CHR_2K_1 = 3'd1;
    localparam logic [2:0] SEL_CHR_1K_0 = 3'd2;
    localparam logic [2:0] SEL_CHR_1K_1 = 3'd3;
    localparam logic [2:0] SEL_CHR_1K_2 = 3'd4;
    localparam logic [2:0] SEL_CHR_1K_3 = 3'd5;
    localparam logic [2:0] SEL_PRG_0    = 3'd6;
    localparam logic [2:0] SEL_PRG_1    = 3'd7;

    localparam logic [0:0] CFG_FOUR_SCREEN = 1'd0;
    localparam logic [0:0] CFG_PRG_COUNT   = 1'd1;

    localparam logic [7:0] PRG_FIXED_LO = 8'hFE;
    localparam logic [7:0] PRG_FIXED_HI = 8'hFF;

    typedef struct packed {
        kind_t                  kind;
        logic [15:0]            address;
        logic [7:0]             data;
        logic [31:0]            ppu_cycle;
        logic [RAM_IDX_W-1:0]   ram_idx;
    } item_t;

    typedef struct packed {
        logic valid;
        logic ready;
    } hs_t;

endpackage

>>> src/mmc3_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mmc3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

>>> src/mmc3_front.sv
// Front end: accepts bus events, classifies them and folds the save RAM index.
module mmc3_front #(
    parameter int RAM_BYTES = 8192
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                busy,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_operation,
    input  logic [15:0]         s_address,
    input  logic [7:0]          s_data,
    input  logic [31:0]         s_ppu_cycle,
    output mmc3_pkg::hs_t       q_hs_out,
    input  logic                q_ready,
    output mmc3_pkg::item_t     q_item
);
    import mmc3_pkg::*;

    localparam logic [15:0] LIM4 = 16'(RAM_BYTES * 4);
    localparam logic [15:0] LIM2 = 16'(RAM_BYTES * 2);
    localparam logic [15:0] LIM1 = 16'(RAM_BYTES);

    logic  f_valid_reg, f_valid_next;
    item_t f_item_reg, f_item_next;
    kind_t kind;
    logic [15:0] v0, v1, v2, v3;
    logic take;

    // Reduce the 13-bit window offset below RAM_BYTES in three steps.
    always_comb begin
        v0 = {3'd0, s_address[12:0]};
        v1 = (v0 >= LIM4) ? v0 - LIM4 : v0;
        v2 = (v1 >= LIM2) ? v1 - LIM2 : v1;
        v3 = (v2 >= LIM1) ? v2 - LIM1 : v2;
    end

    always_comb begin
        kind = KIND_NONE;
        case (s_operation)
            OP_CPU_WRITE: begin
                if (s_address[15]) kind = KIND_REG_WR;
                else if (s_address[14:13] == 2'b11) kind = KIND_RAM_WR;
            end
            OP_CPU_READ: begin
                if (s_address[15]) kind = KIND_PRG_RD;
                else if (s_address[14:13] == 2'b11) kind = KIND_RAM_RD;
            end
            OP_PPU:  kind = KIND_PPU;
            default: kind = KIND_NONE;
        endcase
    end

    assign s_ready = !busy && (!f_valid_reg || q_ready);
    assign take    = s_valid && s_ready;

    always_comb begin
        f_valid_next = f_valid_reg;
        f_item_next  = f_item_reg;
        if (f_valid_reg && q_ready) f_valid_next = 1'b0;
        if (take) begin
            f_valid_next         = 1'b1;
            f_item_next.kind      = kind;
            f_item_next.address   = s_address;
            f_item_next.data      = s_data;
            f_item_next.ppu_cycle = s_ppu_cycle;
            f_item_next.ram_idx   = v3[RAM_IDX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else begin
            f_valid_reg <= f_valid_next;
        end
        f_item_reg <= f_item_next;
    end

    assign q_hs_out.valid = f_valid_reg;
    assign q_hs_out.ready = s_ready;
    assign q_item         = f_item_reg;
endmodule

>>> src/mmc3_queue.sv
// Short queue between the front end and the execute stage.
module mmc3_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  mmc3_pkg::item_t push_item,
    output logic            not_full,
    input  logic            pop,
    output logic            not_empty,
    output mmc3_pkg::item_t head
);
    import mmc3_pkg::*;
    `include "mmc3_bank_mapper_irq_unit_macros.svh"

    item_t              slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]    count_reg, count_next;
    logic               do_push;

    assign not_full  = count_reg != (QPTR_W+1)'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign do_push   = push && not_full;
    assign head      = slots[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            slots[wr_ptr_reg] <= push_item;
        end
    end

    `MMC3_ASSERT(a_q_no_underflow, aclk, aresetn, !(pop && !not_empty), "pop from empty queue")
    `MMC3_ASSERT(a_q_bound, aclk, aresetn, count_reg <= (QPTR_W+1)'(QUEUE_DEPTH), "queue overfilled")
    `MMC3_ASSERT_IMPLIES(a_q_ptrs, aclk, aresetn, count_reg == '0, wr_ptr_reg == rd_ptr_reg, "empty queue with split pointers")
endmodule

>>> src/mmc3_back.sv
// Execute stage: mapper registers, IRQ counter, save RAM and result register.
module mmc3_back #(
    parameter int RAM_BYTES         = 8192,
    parameter int A12_FILTER_CYCLES = 16
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_we,
    input  logic [0:0]      cfg_index,
    input  logic [6:0]      cfg_data,
    output logic            busy,
    input  logic            q_valid,
    output logic            q_pop,
    input  mmc3_pkg::item_t item,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [7:0]      m_read_data,
    output logic            m_ram_hit,
    output logic [7:0]      m_bank,
    output logic            m_irq,
    output logic            m_hmirror
);
    import mmc3_pkg::*;
    `include "mmc3_bank_mapper_irq_unit_macros.svh"

    localparam int AW = $clog2(RAM_BYTES);

    logic       four_screen_reg;
    logic [6:0] prg_count_reg;

    logic [7:0] cmd_reg, cmd_next;
    logic [7:0] chr_reg [8];
    logic [7:0] chr_next [8];
    logic [5:0] prg_reg [2];
    logic [5:0] prg_next [2];
    logic [7:0] latch_reg, latch_next, count_reg, count_next, count_tmp;
    logic       irq_en_reg, irq_en_next, irq_line_reg, irq_line_next;
    logic       ram_en_reg, ram_en_next, ram_wr_reg, ram_wr_next;
    logic       a12_reg, a12_next, mirror_reg, mirror_next;
    logic [31:0] edge_reg, edge_next, gap;

    logic          clearing_reg, clearing_next;
    logic [AW-1:0] clr_idx_reg, clr_idx_next;

    logic       w_valid_reg, w_rd_reg, w_hit_reg, w_irq_reg, w_mirror_reg;
    logic [7:0] w_bank_reg;

    logic       go, odd, item_ram_wr, item_ram_rd;
    logic [1:0] slot;
    logic [7:0] raw, mask, bank, ram_q;
    logic [2:0] chr_idx;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;

    assign busy  = clearing_reg;
    assign go    = q_valid && (!w_valid_reg || m_ready) && !clearing_reg;
    assign q_pop = go;
    assign odd   = item.address[0];
    assign gap   = item.ppu_cycle - edge_reg;
    assign mask  = {1'b0, prg_count_reg} - 8'd1;

    always_comb begin
        cmd_next      = cmd_reg;
        chr_next      = chr_reg;
        prg_next      = prg_reg;
        latch_next    = latch_reg;
        count_next    = count_reg;
        irq_en_next   = irq_en_reg;
        irq_line_next = irq_line_reg;
        ram_en_next   = ram_en_reg;
        ram_wr_next   = ram_wr_reg;
        a12_next      = a12_reg;
        edge_next     = edge_reg;
        mirror_next   = mirror_reg;
        count_tmp     = (count_reg == 8'd0) ? latch_reg : count_reg - 8'd1;
        if (go && item.kind == KIND_REG_WR) begin
            case (item.address[14:13])
                REG_BANK: begin
                    if (!odd) begin
                        cmd_next = item.data;
                    end else begin
                        case (cmd_reg[2:0])
                            SEL_CHR_2K_0: begin
                                chr_next[0] = item.data & 8'hFE;
                                chr_next[1] = item.data | 8'h01;
                            end
                            SEL_CHR_2K_1: begin
                                chr_next[2] = item.data & 8'hFE;
                                chr_next[3] = item.data | 8'h01;
                            end
                            SEL_CHR_1K_0: chr_next[4] = item.data;
                            SEL_CHR_1K_1: chr_next[5] = item.data;
                            SEL_CHR_1K_2: chr_next[6] = item.data;
                            SEL_CHR_1K_3: chr_next[7] = item.data;
                            SEL_PRG_0:    prg_next[0] = item.data[5:0];
                            default:      prg_next[1] = item.data[5:0];
                        endcase
                    end
                end
                REG_MIRROR: begin
                    if (odd) begin
                        ram_en_next = item.data[7];
                        ram_wr_next = !item.data[6];
                    end else if (!four_screen_reg) begin
                        mirror_next = item.data[0];
                    end
                end
                REG_LATCH: begin
                    if (odd) count_next = 8'd0;
                    else latch_next = item.data;
                end
                default: begin
                    irq_en_next = odd;
                    if (!odd) irq_line_next = 1'b0;
                end
            endcase
        end
        if (go && item.kind == KIND_PPU) begin
            // A rising edge of PPU address bit 12 that passes the gap filter clocks the scanline counter.
            if (item.address[12] && !a12_reg) begin
                if (gap >= 32'(A12_FILTER_CYCLES)) begin
                    count_next = count_tmp;
                    if (irq_en_reg && count_tmp == 8'd0) irq_line_next = 1'b1;
                end
                edge_next = item.ppu_cycle;
            end
            a12_next = item.address[12];
        end
    end

    always_comb begin
        slot = item.address[14:13];
        if (!slot[0]) slot[1] = slot[1] ^ cmd_next[6];
        case (slot)
            2'd0:    raw = {2'b00, prg_next[0]};
            2'd1:    raw = {2'b00, prg_next[1]};
            2'd2:    raw = PRG_FIXED_LO;
            default: raw = PRG_FIXED_HI;
        endcase
        chr_idx = item.address[12:10] ^ {cmd_reg[7], 2'b00};
        case (item.kind)
            KIND_REG_WR, KIND_PRG_RD: bank = raw & mask;
            KIND_PPU:                 bank = chr_reg[chr_idx];
            default:                  bank = 8'd0;
        endcase
    end

    assign item_ram_wr = item.kind == KIND_RAM_WR && ram_en_reg && ram_wr_reg
                         && !four_screen_reg;
    assign item_ram_rd = item.kind == KIND_RAM_RD && ram_en_reg && !four_screen_reg;

    always_comb begin
        clearing_next = clearing_reg;
        clr_idx_next  = clr_idx_reg;
        if (clearing_reg) begin
            clr_idx_next = clr_idx_reg + 1'b1;
            if (clr_idx_reg == AW'(RAM_BYTES - 1)) clearing_next = 1'b0;
        end
        ram_we    = clearing_reg || (go && item_ram_wr);
        ram_waddr = clearing_reg ? clr_idx_reg : item.ram_idx[AW-1:0];
        ram_wdata = clearing_reg ? 8'd0 : item.data;
    end

    mmc3_ram #(.WIDTH(8), .DEPTH(RAM_BYTES)) u_save_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (go),
        .raddr (item.ram_idx[AW-1:0]),
        .rdata (ram_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            four_screen_reg <= 1'b0;
            prg_count_reg   <= 7'd64;
            cmd_reg         <= '0;
            chr_reg         <= '{default: '0};
            prg_reg         <= '{default: '0};
            latch_reg       <= '0;
            count_reg       <= '0;
            irq_en_reg      <= 1'b0;
            irq_line_reg    <= 1'b0;
            ram_en_reg      <= 1'b1;
            ram_wr_reg      <= 1'b1;
            a12_reg         <= 1'b1;
            edge_reg        <= '0;
            mirror_reg      <= 1'b0;
            clearing_reg    <= 1'b1;
            clr_idx_reg     <= '0;
            w_valid_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_FOUR_SCREEN) four_screen_reg <= cfg_data[0];
                else prg_count_reg <= cfg_data;
            end
            cmd_reg      <= cmd_next;
            chr_reg      <= chr_next;
            prg_reg      <= prg_next;
            latch_reg    <= latch_next;
            count_reg    <= count_next;
            irq_en_reg   <= irq_en_next;
            irq_line_reg <= irq_line_next;
            ram_en_reg   <= ram_en_next;
            ram_wr_reg   <= ram_wr_next;
            a12_reg      <= a12_next;
            edge_reg     <= edge_next;
            mirror_reg   <= mirror_next;
            clearing_reg <= clearing_next;
            clr_idx_reg  <= clr_idx_next;
            if (go) w_valid_reg <= 1'b1;
            else if (m_ready) w_valid_reg <= 1'b0;
        end
        // Hold the result while the consumer stalls.
        if (go) begin
            w_rd_reg     <= item_ram_rd;
            w_hit_reg    <= item_ram_rd || item_ram_wr;
            w_bank_reg   <= bank;
            w_irq_reg    <= irq_line_next;
            w_mirror_reg <= mirror_next;
        end
    end

    assign m_valid     = w_valid_reg;
    assign m_read_data = w_rd_reg ? ram_q : 8'd0;
    assign m_ram_hit   = w_hit_reg;
    assign m_bank      = w_bank_reg;
    assign m_irq       = w_irq_reg;
    assign m_hmirror   = w_mirror_reg;

    `MMC3_ASSERT_IMPLIES(a_no_exec_in_clear, aclk, aresetn, clearing_reg, !go, "item executed during RAM clear")
    `MMC3_ASSERT_IMPLIES(a_irq_from_ppu, aclk, aresetn, $rose(irq_line_reg), $past(go && item.kind == KIND_PPU), "IRQ raised without PPU event")
    `MMC3_ASSERT_IMPLIES(a_hold_stalled, aclk, aresetn, w_valid_reg && !m_ready, ##1 (w_valid_reg && $stable(w_bank_reg) && $stable(ram_q)), "stalled result changed")
endmodule

>>> src/mmc3_bank_mapper_irq_unit.sv
// Top level of the MMC3-style bank mapper with scanline IRQ.
//  channel | direction | ports                                   | accepted when
//  s_      | in        | operation, address, data, ppu_cycle     | s_valid && s_ready
//  m_      | out       | read_data, ram_hit, bank, irq, hmirror  | m_valid && m_ready
//  cfg_    | in        | cfg_index, cfg_data                     | cfg_we
// One event per clock sustained while m_ready stays high and no RAM clear runs; each event
// passes the input register, the queue and the execute stage's result register in turn.
// After reset the save RAM is cleared one byte a cycle, with s_ready low until it is done.
// A stalled m_ side fills the four-entry queue, then the input register, then drops s_ready.
module mmc3_bank_mapper_irq_unit #(
    parameter int RAM_BYTES         = 8192,
    parameter int A12_FILTER_CYCLES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [15:0] s_address,
    input  logic [7:0]  s_data,
    input  logic [31:0] s_ppu_cycle,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_read_data,
    output logic        m_ram_hit,
    output logic [7:0]  m_bank,
    output logic        m_irq,
    output logic        m_hmirror,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [6:0]  cfg_data
);
    import mmc3_pkg::*;

    hs_t   f_hs;
    item_t f_item, q_head;
    logic  busy, q_not_full, q_not_empty, q_pop;

    mmc3_front #(.RAM_BYTES(RAM_BYTES)) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .busy        (busy),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_address   (s_address),
        .s_data      (s_data),
        .s_ppu_cycle (s_ppu_cycle),
        .q_hs_out    (f_hs),
        .q_ready     (q_not_full),
        .q_item      (f_item)
    );

    mmc3_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (f_hs.valid),
        .push_item (f_item),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    mmc3_back #(
        .RAM_BYTES         (RAM_BYTES),
        .A12_FILTER_CYCLES (A12_FILTER_CYCLES)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .busy        (busy),
        .q_valid     (q_not_empty),
        .q_pop       (q_pop),
        .item        (q_head),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_read_data (m_read_data),
        .m_ram_hit   (m_ram_hit),
        .m_bank      (m_bank),
        .m_irq       (m_irq),
        .m_hmirror   (m_hmirror)
    );
endmodule
